// ===== src/ascg_pkg.sv =====
// ascg_pkg: shared types and constants of the anaglyph to side-by-side gray block.
// No dependencies; the top level, ascg_front, ascg_back and the testbench import it.
package ascg_pkg;

	localparam int PIX_BITS       = 8;
	localparam int COEF_BITS      = 16;
	localparam int ROW_WIDTH_BITS = 12;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int PROD_BITS      = COEF_BITS + PIX_BITS + 1;
	localparam int SUM_BITS       = PROD_BITS + 2;
	localparam int QUEUE_DEPTH    = 4;

	// register map of the write port
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROW_WIDTH        = 3'd0,
		REG_COEF_LEFT_RED    = 3'd1,
		REG_COEF_LEFT_GREEN  = 3'd2,
		REG_COEF_LEFT_BLUE   = 3'd3,
		REG_COEF_RIGHT_RED   = 3'd4,
		REG_COEF_RIGHT_GREEN = 3'd5,
		REG_COEF_RIGHT_BLUE  = 3'd6
	} cfg_reg_t;

	localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET        = 12'd1280;
	localparam logic signed [COEF_BITS-1:0] COEF_LEFT_RED_RESET    = -16'sd154;
	localparam logic signed [COEF_BITS-1:0] COEF_LEFT_GREEN_RESET  = 16'sd5342;
	localparam logic signed [COEF_BITS-1:0] COEF_LEFT_BLUE_RESET   = 16'sd1038;
	localparam logic signed [COEF_BITS-1:0] COEF_RIGHT_RED_RESET   = 16'sd3072;
	localparam logic signed [COEF_BITS-1:0] COEF_RIGHT_GREEN_RESET = -16'sd267;
	localparam logic signed [COEF_BITS-1:0] COEF_RIGHT_BLUE_RESET  = -16'sd52;

	// what the back end has to do with one word
	typedef struct packed {
		logic wr_en;  // pixel: write both gray values
		logic emit;   // a previous row exists: send one byte pair
		logic last;   // pair completes an output row
		logic sel0;   // first byte comes from the right row store
		logic sel1;   // second byte comes from the right row store
	} item_ctl_t;

endpackage

// ===== src/anaglyph_to_side_by_side_gray.sv =====
// Anaglyph to side-by-side gray: an accepted input word passes front stages 1 and 2, the queue
// and the back-end read stage before its result word is loaded into the output register; one
// word per cycle while m_tready does not stall the output (4-entry queue between ends).
// Reset: arst_n clears row position, bank and row-ready state, pipeline valids and the
// queue, and loads the register defaults; row stores are not cleared and need no pass.
// Depends on ascg_pkg, ascg_front, ascg_queue, ascg_back.
module anaglyph_to_side_by_side_gray #(
	parameter int MAX_WIDTH = 2048,
	parameter int FRAC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port, index per register map in the package
	input  logic                                cfg_we,
	input  logic [ascg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ascg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// input words
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,  // red[7:0], green[15:8], blue[23:16]
	input  logic                                s_tuser,  // opcode: 0 pixel, 1 drain
	// result words
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,  // first_byte[7:0], second_byte[15:8]
	output logic                                m_tlast   // row_end
);
	import ascg_pkg::*;

	localparam int AW = $clog2(2 * MAX_WIDTH);
	localparam int QW = $bits(item_ctl_t) + 3 * AW + 2 * PIX_BITS;

	logic                push, pop, q_valid;
	item_ctl_t           push_ctl, pop_ctl;
	logic [AW-1:0]       push_waddr, push_raddr0, push_raddr1;
	logic [AW-1:0]       pop_waddr, pop_raddr0, pop_raddr1;
	logic [PIX_BITS-1:0] push_wleft, push_wright, pop_wleft, pop_wright;
	logic [QW-1:0]       q_din, q_dout;

	// Front end: registers, row position and bank, products in the accept cycle,
	// sums, clamp and store addresses one stage later. It reserves a queue slot
	// for each accepted word, so it never stalls once a word is in.
	ascg_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.pop         (pop),
		.push        (push),
		.push_ctl    (push_ctl),
		.push_waddr  (push_waddr),
		.push_wleft  (push_wleft),
		.push_wright (push_wright),
		.push_raddr0 (push_raddr0),
		.push_raddr1 (push_raddr1)
	);

	assign q_din = {push_ctl, push_waddr, push_raddr0, push_raddr1, push_wleft, push_wright};

	ascg_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.pop    (pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	assign {pop_ctl, pop_waddr, pop_raddr0, pop_raddr1, pop_wleft, pop_wright} = q_dout;

	// Back end: write and read of the row stores happen on the same pop, so the
	// row finished by one word is readable by the very next word.
	ascg_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.ctl      (pop_ctl),
		.waddr    (pop_waddr),
		.wleft    (pop_wleft),
		.wright   (pop_wright),
		.raddr0   (pop_raddr0),
		.raddr1   (pop_raddr1),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== src/ascg_queue.sv =====
// ascg_queue: small first-in first-out queue between the front and back ends.
// Depends on nothing but its parameters; the caller keeps it from overflowing.
module ascg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             valid
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign dout  = slot_q[rd_ptr_q];
	assign valid = (count_q != '0);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNTW'(DEPTH)) || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");
`endif

endmodule

// ===== src/ascg_front.sv =====
// ascg_front: input side. Holds the registers, tracks row position and bank,
// forms both gray values and the store addresses. Uses ascg_pkg.
module ascg_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int FRAC_BITS = 12,
	localparam int AW = $clog2(2 * MAX_WIDTH)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ascg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [ascg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [23:0]                          s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 pop,
	output logic                                 push,
	output ascg_pkg::item_ctl_t                  push_ctl,
	output logic [AW-1:0]                        push_waddr,
	output logic [ascg_pkg::PIX_BITS-1:0]        push_wleft,
	output logic [ascg_pkg::PIX_BITS-1:0]        push_wright,
	output logic [AW-1:0]                        push_raddr0,
	output logic [AW-1:0]                        push_raddr1
);
	import ascg_pkg::*;

	localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int QCW  = $clog2(QUEUE_DEPTH + 1);

	// registers
	logic [ROW_WIDTH_BITS-1:0]   row_width_q;
	logic signed [COEF_BITS-1:0] coef_lr_q, coef_lg_q, coef_lb_q;
	logic signed [COEF_BITS-1:0] coef_rr_q, coef_rg_q, coef_rb_q;

	// row tracking
	logic [CW-1:0] column_q;
	logic          write_bank_q;
	logic          row_ready_q;
	logic [QCW-1:0] reserved_q;

	logic          acc;
	logic [WW-1:0] width_eff;
	logic [CW-1:0] col_cur;
	logic          row_last;
	logic [PIX_BITS-1:0] red, green, blue;
	logic signed [PROD_BITS-1:0] p_lr, p_lg, p_lb, p_rr, p_rg, p_rb;

	// stage 1
	logic          valid_s1;
	logic          write_s1, emit_s1, last_s1, bank_s1;
	logic [CW-1:0] col_s1;
	logic [WW-1:0] width_s1;
	logic signed [PROD_BITS-1:0] p_lr_s1, p_lg_s1, p_lb_s1, p_rr_s1, p_rg_s1, p_rb_s1;

	// stage 2
	logic          valid_s2;
	item_ctl_t     ctl_s2;
	logic [AW-1:0] waddr_s2, raddr0_s2, raddr1_s2;
	logic [PIX_BITS-1:0] wleft_s2, wright_s2;

	logic signed [SUM_BITS-1:0] sum_left, sum_right;
	logic [AW-1:0] pos0, pos1, wext, idx0, idx1, rbase, wbase;
	logic          sel0, sel1;

	function automatic logic [PIX_BITS-1:0] clamp_gray(logic signed [SUM_BITS-1:0] s);
		logic [PIX_BITS-1:0] g;
		if (s[SUM_BITS-1]) begin
			g = '0;
		end else if (|s[SUM_BITS-2:FRAC_BITS+PIX_BITS]) begin
			g = '1;
		end else begin
			g = s[FRAC_BITS+PIX_BITS-1:FRAC_BITS];
		end
		return g;
	endfunction

	function automatic logic signed [SUM_BITS-1:0] ext_prod(logic signed [PROD_BITS-1:0] p);
		return {{(SUM_BITS - PROD_BITS){p[PROD_BITS-1]}}, p};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
			coef_lr_q   <= COEF_LEFT_RED_RESET;
			coef_lg_q   <= COEF_LEFT_GREEN_RESET;
			coef_lb_q   <= COEF_LEFT_BLUE_RESET;
			coef_rr_q   <= COEF_RIGHT_RED_RESET;
			coef_rg_q   <= COEF_RIGHT_GREEN_RESET;
			coef_rb_q   <= COEF_RIGHT_BLUE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_WIDTH:        row_width_q <= cfg_data[ROW_WIDTH_BITS-1:0];
				REG_COEF_LEFT_RED:    coef_lr_q   <= cfg_data;
				REG_COEF_LEFT_GREEN:  coef_lg_q   <= cfg_data;
				REG_COEF_LEFT_BLUE:   coef_lb_q   <= cfg_data;
				REG_COEF_RIGHT_RED:   coef_rr_q   <= cfg_data;
				REG_COEF_RIGHT_GREEN: coef_rg_q   <= cfg_data;
				REG_COEF_RIGHT_BLUE:  coef_rb_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate the width to 2..MAX_WIDTH
	always_comb begin
		if (row_width_q < ROW_WIDTH_BITS'(2)) begin
			width_eff = WW'(2);
		end else if ({1'b0, row_width_q} > (ROW_WIDTH_BITS + 1)'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(row_width_q);
		end
	end

	// a width shrunk mid-row pulls the column back to the new last one
	always_comb begin
		if (AW'(column_q) >= AW'(width_eff)) begin
			col_cur = CW'(width_eff - 1'b1);
		end else begin
			col_cur = column_q;
		end
	end

	assign row_last = (AW'(col_cur) == AW'(width_eff) - AW'(1));
	assign s_tready = (reserved_q < QCW'(QUEUE_DEPTH));
	assign acc      = s_tvalid && s_tready;

	assign red   = s_tdata[7:0];
	assign green = s_tdata[15:8];
	assign blue  = s_tdata[23:16];

	assign p_lr = coef_lr_q * $signed({1'b0, red});
	assign p_lg = coef_lg_q * $signed({1'b0, green});
	assign p_lb = coef_lb_q * $signed({1'b0, blue});
	assign p_rr = coef_rr_q * $signed({1'b0, red});
	assign p_rg = coef_rg_q * $signed({1'b0, green});
	assign p_rb = coef_rb_q * $signed({1'b0, blue});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			write_bank_q <= 1'b0;
			row_ready_q  <= 1'b0;
			reserved_q   <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			if (acc) begin
				if (row_last) begin
					column_q     <= '0;
					write_bank_q <= !write_bank_q;
					row_ready_q  <= 1'b1;
				end else begin
					column_q <= col_cur + 1'b1;
				end
			end
			if (acc && !pop) begin
				reserved_q <= reserved_q + 1'b1;
			end else if (pop && !acc) begin
				reserved_q <= reserved_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			write_s1 <= !s_tuser;
			emit_s1  <= row_ready_q;
			last_s1  <= row_last;
			bank_s1  <= write_bank_q;
			col_s1   <= col_cur;
			width_s1 <= width_eff;
			p_lr_s1  <= p_lr;
			p_lg_s1  <= p_lg;
			p_lb_s1  <= p_lb;
			p_rr_s1  <= p_rr;
			p_rg_s1  <= p_rg;
			p_rb_s1  <= p_rb;
		end
	end

	assign sum_left  = ext_prod(p_lr_s1) + ext_prod(p_lg_s1) + ext_prod(p_lb_s1);
	assign sum_right = ext_prod(p_rr_s1) + ext_prod(p_rg_s1) + ext_prod(p_rb_s1);

	// output positions 2c and 2c+1; past the width they fall in the right row
	assign pos0  = {col_s1, 1'b0};
	assign pos1  = {col_s1, 1'b1};
	assign wext  = AW'(width_s1);
	assign sel0  = (pos0 >= wext);
	assign sel1  = (pos1 >= wext);
	assign idx0  = sel0 ? pos0 - wext : pos0;
	assign idx1  = sel1 ? pos1 - wext : pos1;
	assign rbase = bank_s1 ? AW'(0) : AW'(MAX_WIDTH);
	assign wbase = bank_s1 ? AW'(MAX_WIDTH) : AW'(0);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ctl_s2.wr_en <= write_s1;
			ctl_s2.emit  <= emit_s1;
			ctl_s2.last  <= last_s1;
			ctl_s2.sel0  <= sel0;
			ctl_s2.sel1  <= sel1;
			waddr_s2     <= wbase + AW'(col_s1);
			raddr0_s2    <= rbase + idx0;
			raddr1_s2    <= rbase + idx1;
			wleft_s2     <= clamp_gray(sum_left);
			wright_s2    <= clamp_gray(sum_right);
		end
	end

	assign push        = valid_s2;
	assign push_ctl    = ctl_s2;
	assign push_waddr  = waddr_s2;
	assign push_wleft  = wleft_s2;
	assign push_wright = wright_s2;
	assign push_raddr0 = raddr0_s2;
	assign push_raddr1 = raddr1_s2;

`ifndef SYNTHESIS
	a_credit_covers_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(QCW'(valid_s1) + QCW'(valid_s2)) <= reserved_q)
		else $error("words in flight exceed reserved queue slots");
`endif

endmodule

// ===== src/ascg_back.sv =====
// ascg_back: output side. Owns the two ping-pong row stores, writes the gray
// values, reads the byte pair and drives the output register. Uses ascg_pkg.
module ascg_back #(
	parameter int MAX_WIDTH = 2048,
	localparam int AW = $clog2(2 * MAX_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  ascg_pkg::item_ctl_t           ctl,
	input  logic [AW-1:0]                 waddr,
	input  logic [ascg_pkg::PIX_BITS-1:0] wleft,
	input  logic [ascg_pkg::PIX_BITS-1:0] wright,
	input  logic [AW-1:0]                 raddr0,
	input  logic [AW-1:0]                 raddr1,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,
	output logic                          m_tlast
);
	import ascg_pkg::*;

	logic [PIX_BITS-1:0] left_mem  [2 * MAX_WIDTH];
	logic [PIX_BITS-1:0] right_mem [2 * MAX_WIDTH];

	logic                b1_valid_s1;
	logic                sel0_s1, sel1_s1, last_s1;
	logic [PIX_BITS-1:0] rd_l0_s1, rd_l1_s1, rd_r0_s1, rd_r1_s1;
	logic                out_adv;

	assign out_adv = !m_tvalid || m_tready;
	assign pop     = q_valid && (!b1_valid_s1 || out_adv);

	always_ff @(posedge clk) begin
		if (pop) begin
			if (ctl.wr_en) begin
				left_mem[waddr] <= wleft;
			end
			rd_l0_s1 <= left_mem[raddr0];
			rd_l1_s1 <= left_mem[raddr1];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (ctl.wr_en) begin
				right_mem[waddr] <= wright;
			end
			rd_r0_s1 <= right_mem[raddr0];
			rd_r1_s1 <= right_mem[raddr1];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sel0_s1 <= ctl.sel0;
			sel1_s1 <= ctl.sel1;
			last_s1 <= ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_s1 <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (pop) begin
				b1_valid_s1 <= ctl.emit;
			end else if (out_adv) begin
				b1_valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				m_tvalid <= b1_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && b1_valid_s1) begin
			m_tdata[7:0]  <= sel0_s1 ? rd_r0_s1 : rd_l0_s1;
			m_tdata[15:8] <= sel1_s1 ? rd_r1_s1 : rd_l1_s1;
			m_tlast       <= last_s1;
		end
	end

`ifndef SYNTHESIS
	a_banks_apart: assert property (@(posedge clk) disable iff (!arst_n)
		pop && ctl.wr_en && ctl.emit |->
			((waddr >= AW'(MAX_WIDTH)) != (raddr0 >= AW'(MAX_WIDTH))))
		else $error("row store read and written in the same bank");
	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		b1_valid_s1 && m_tvalid && !m_tready |-> !pop)
		else $error("read stage overwritten while output stalled");
`endif

endmodule

// ===== tb/sv/anaglyph_to_side_by_side_gray_tb.sv =====
// Self-checking testbench for anaglyph_to_side_by_side_gray: random bursty stream in,
// stalling sink out, every result word checked against a cycle-free row-store predictor.
// Depends on ascg_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module anaglyph_to_side_by_side_gray_tb;
	import ascg_pkg::*;

	localparam int MAX_WIDTH     = 2048;
	localparam int FRAC_BITS     = 12;
	localparam int FILL_WIDTH    = 160;   // prefix of both banks written before any read
	localparam int SETTLE_CYCLES = 12;    // pipeline + queue + margin
	localparam int HOLD_AT       = 100;   // sink holds off after this many words
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;  // cycles with no word moved on either side
	localparam int MAX_REPORTS   = 40;
	localparam int RANDOM_ITEMS  = 650;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_MOSTLY_READY,
		RX_MOSTLY_BUSY,
		RX_TOGGLE
	} rx_mode_t;

	typedef struct {
		opcode_t    op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       row_end;
	} byte_pair_t;

	// DUT ports; every input starts at a known value
	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [23:0]               s_tdata   = '0;  // red[7:0], green[15:8], blue[23:16]
	logic                      s_tuser   = 1'b0; // opcode
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [15:0]               m_tdata;          // first_byte[7:0], second_byte[15:8]
	logic                      m_tlast;          // row_end

	anaglyph_to_side_by_side_gray #(
		.MAX_WIDTH(MAX_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: register copy, ping-pong row stores, row position
	// ------------------------------------------------------------------
	logic [ROW_WIDTH_BITS-1:0] width_reg = ROW_WIDTH_RESET;
	logic signed [15:0] k_left_red    = COEF_LEFT_RED_RESET;
	logic signed [15:0] k_left_green  = COEF_LEFT_GREEN_RESET;
	logic signed [15:0] k_left_blue   = COEF_LEFT_BLUE_RESET;
	logic signed [15:0] k_right_red   = COEF_RIGHT_RED_RESET;
	logic signed [15:0] k_right_green = COEF_RIGHT_GREEN_RESET;
	logic signed [15:0] k_right_blue  = COEF_RIGHT_BLUE_RESET;

	// X until written, so a stray read of an unwritten entry shows up as a mismatch
	logic [7:0] left_store  [2][MAX_WIDTH];
	logic [7:0] right_store [2][MAX_WIDTH];
	int         col       = 0;
	int         wbank     = 0;
	bit         row_ready = 1'b0;

	pixel_t     pixel_q[$];    // words waiting to be offered
	byte_pair_t due_pairs[$];  // byte pairs predicted, not yet seen
	int         errors = 0;

	function automatic int eff_width(input logic [ROW_WIDTH_BITS-1:0] w);
		if (w < 2)
			return 2;
		if (w > MAX_WIDTH)
			return MAX_WIDTH;
		return int'(w);
	endfunction

	// exact weighted sum, floor to integer, clamp to 0..255
	function automatic logic [7:0] gray_level(input logic signed [15:0] kr, kg, kb,
			input logic [7:0] r, g, b);
		logic signed [26:0] acc;
		acc = kr * $signed({1'b0, r}) + kg * $signed({1'b0, g}) + kb * $signed({1'b0, b});
		if (acc < 0)
			return 8'd0;
		if (acc[26:FRAC_BITS] > 255)
			return 8'hff;
		return acc[FRAC_BITS+7:FRAC_BITS];
	endfunction

	// output row = left row then right row; odd widths let a pair straddle both
	function automatic logic [7:0] row_byte(input int bank, input int pos, input int w);
		if (pos < w)
			return left_store[bank][pos];
		pos -= w;
		if (pos < w)
			return right_store[bank][pos];
		return 8'd0;
	endfunction

	task automatic convert_pixel(input pixel_t px);
		int         w;
		int         rb;
		logic       at_end;
		byte_pair_t pr;
		w = eff_width(width_reg);
		// width shrunk under a running row: clamp, and this word closes the row
		if (col >= w)
			col = w - 1;
		at_end = (col == w - 1);
		if (row_ready) begin
			rb = wbank ^ 1;
			pr.first_byte  = row_byte(rb, 2 * col, w);
			pr.second_byte = row_byte(rb, 2 * col + 1, w);
			pr.row_end     = at_end;
			due_pairs.push_back(pr);
		end
		if (px.op == OP_PIXEL) begin
			left_store[wbank][col]  = gray_level(k_left_red, k_left_green, k_left_blue,
				px.red, px.green, px.blue);
			right_store[wbank][col] = gray_level(k_right_red, k_right_green, k_right_blue,
				px.red, px.green, px.blue);
		end
		// drain rows also flip the bank and mark a row ready
		if (at_end) begin
			col       = 0;
			wbank    ^= 1;
			row_ready = 1'b1;
		end else begin
			col++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of random length, random gaps, valid held until taken
	// ------------------------------------------------------------------
	pixel_t cur_px;
	int     burst_left = 1;
	int     gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				convert_pixel(cur_px);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					cur_px = pixel_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_px.op;
					s_tdata  <= {cur_px.blue, cur_px.green, cur_px.red};
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						// a third of the bursts run straight into the next one
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stall pattern of its own, one long hold-off, field checks
	// ------------------------------------------------------------------
	rx_mode_t   rx_mode     = RX_OPEN;
	int         rx_tick     = 0;
	int         hold_left   = 0;
	int         words_seen  = 0;
	byte_pair_t want;

	task automatic mismatch(input string fld, input logic [7:0] want_v, got_v);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s expected %0d got %0d", $time, fld, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				words_seen++;
				if (due_pairs.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: word with nothing due, expected none got data %h last %b",
							$time, m_tdata, m_tlast);
				end else begin
					want = due_pairs.pop_front();
					if (m_tdata[7:0] !== want.first_byte)
						mismatch("first_byte", want.first_byte, m_tdata[7:0]);
					if (m_tdata[15:8] !== want.second_byte)
						mismatch("second_byte", want.second_byte, m_tdata[15:8]);
					if (m_tlast !== want.row_end)
						mismatch("row_end", want.row_end, m_tlast);
				end
				// long hold-off while the source keeps pushing: fills the queue
				if (words_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (rx_tick == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_tick = $urandom_range(20, 80);
				end else begin
					rx_tick--;
				end
				case (rx_mode)
					RX_OPEN:         m_tready <= 1'b1;
					RX_MOSTLY_READY: m_tready <= ($urandom_range(0, 9) < 7);
					RX_MOSTLY_BUSY:  m_tready <= ($urandom_range(0, 9) < 3);
					default:         m_tready <= !m_tready;
				endcase
			end
		end
	end

	// watchdog: nothing moved on either side for too long
	int quiet = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("anaglyph_to_side_by_side_gray_tb: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_pixel(input opcode_t op, input logic [7:0] r, g, b);
		pixel_t px;
		px.op    = op;
		px.red   = r;
		px.green = g;
		px.blue  = b;
		pixel_q.push_back(px);
	endtask

	// wait for an empty pipe: all offered, all results in, then the latency
	task automatic settle();
		do
			@(negedge clk);
		while (pixel_q.size() != 0 || s_tvalid || due_pairs.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_ROW_WIDTH:        width_reg     = val[ROW_WIDTH_BITS-1:0];
			REG_COEF_LEFT_RED:    k_left_red    = val;
			REG_COEF_LEFT_GREEN:  k_left_green  = val;
			REG_COEF_LEFT_BLUE:   k_left_blue   = val;
			REG_COEF_RIGHT_RED:   k_right_red   = val;
			REG_COEF_RIGHT_GREEN: k_right_green = val;
			default:              k_right_blue  = val;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_config(input logic [15:0] w, lr, lg, lb, rr, rg, rb);
		write_reg(REG_ROW_WIDTH, w);
		write_reg(REG_COEF_LEFT_RED, lr);
		write_reg(REG_COEF_LEFT_GREEN, lg);
		write_reg(REG_COEF_LEFT_BLUE, lb);
		write_reg(REG_COEF_RIGHT_RED, rr);
		write_reg(REG_COEF_RIGHT_GREEN, rg);
		write_reg(REG_COEF_RIGHT_BLUE, rb);
		end_writes();
	endtask

	// leans on the channel extremes
	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly weights that land inside 0..255, sometimes rails or raw bits
	function automatic logic [15:0] rand_coef();
		int v;
		case ($urandom_range(0, 9))
			0:       v = -32768;
			1:       v = 32767;
			2, 3, 4, 5: v = int'($urandom_range(0, 12000)) - 6000;
			6, 7:    v = int'($urandom_range(0, 600)) - 300;
			default: v = int'($urandom_range(0, 65535));
		endcase
		return v[15:0];
	endfunction

	// small rows mostly; a few below range or up to the filled prefix
	function automatic logic [15:0] rand_width();
		case ($urandom_range(0, 19))
			0:       return 16'($urandom_range(0, 1));
			1:       return 16'($urandom_range(FILL_WIDTH - 24, FILL_WIDTH));
			2, 3, 4: return 16'($urandom_range(25, 120));
			default: return 16'($urandom_range(2, 24));
		endcase
	endfunction

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			push_pixel(($urandom_range(0, 99) < 12) ? OP_DRAIN : OP_PIXEL,
				rand_chan(), rand_chan(), rand_chan());
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	int w_now;
	int rand_done;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// Fill the low FILL_WIDTH entries of both banks; no later row reads past
		// that prefix. Row two reads back row one.
		write_config(16'(FILL_WIDTH), COEF_LEFT_RED_RESET, COEF_LEFT_GREEN_RESET,
			COEF_LEFT_BLUE_RESET, COEF_RIGHT_RED_RESET, COEF_RIGHT_GREEN_RESET,
			COEF_RIGHT_BLUE_RESET);
		push_pixel(OP_PIXEL, 8'd0, 8'd0, 8'd0);
		push_pixel(OP_PIXEL, 8'hff, 8'hff, 8'hff);
		push_pixel(OP_PIXEL, 8'hff, 8'd0, 8'd0);
		push_pixel(OP_PIXEL, 8'd0, 8'hff, 8'd0);
		push_pixel(OP_PIXEL, 8'd0, 8'd0, 8'hff);
		for (int i = 5; i < FILL_WIDTH; i++)
			push_pixel(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
		settle();
		for (int i = 0; i < FILL_WIDTH; i++)
			push_pixel(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
		settle();

		// width below range, weights on the rails: left saturates high, right low;
		// a full drain row, then the next row re-emits the old bank
		write_config(16'd0, 16'sd32767, 16'sd32767, 16'sd32767,
			-16'sd32768, -16'sd32768, -16'sd32768);
		push_pixel(OP_PIXEL, 8'd0, 8'd0, 8'd0);
		push_pixel(OP_PIXEL, 8'hff, 8'hff, 8'hff);
		push_pixel(OP_DRAIN, 8'h5a, 8'ha5, 8'h3c);
		push_pixel(OP_DRAIN, 8'hc3, 8'h0f, 8'hf0);
		push_pixel(OP_PIXEL, 8'd1, 8'd0, 8'd0);
		push_pixel(OP_PIXEL, 8'd0, 8'd1, 8'd0);
		settle();

		// width 1 (also clamps to 2), rails swapped; a drain closes the second row
		write_config(16'd1, -16'sd32768, -16'sd32768, -16'sd32768,
			16'sd32767, 16'sd32767, 16'sd32767);
		push_pixel(OP_PIXEL, 8'hff, 8'hff, 8'hff);
		push_pixel(OP_PIXEL, 8'd0, 8'd0, 8'd1);
		push_pixel(OP_PIXEL, 8'd17, 8'd34, 8'd51);
		push_pixel(OP_DRAIN, 8'd0, 8'd0, 8'd0);
		settle();

		// odd width: pairs straddle the left and right rows
		write_config(16'd3, COEF_LEFT_RED_RESET, COEF_LEFT_GREEN_RESET,
			COEF_LEFT_BLUE_RESET, COEF_RIGHT_RED_RESET, COEF_RIGHT_GREEN_RESET,
			COEF_RIGHT_BLUE_RESET);
		push_pixel(OP_PIXEL, 8'd200, 8'd10, 8'd30);
		push_pixel(OP_PIXEL, 8'd10, 8'd200, 8'd30);
		push_pixel(OP_PIXEL, 8'd10, 8'd30, 8'd200);
		push_pixel(OP_PIXEL, 8'd255, 8'd128, 8'd0);
		push_pixel(OP_DRAIN, 8'd1, 8'd2, 8'd3);
		push_pixel(OP_PIXEL, 8'd0, 8'd128, 8'd255);
		settle();

		// width above range saturates to the top: a short run at the front of
		// that row, then a shrink closes it on the next word
		write_reg(REG_ROW_WIDTH, 16'd4095);
		end_writes();
		for (int i = 0; i < 6; i++)
			push_pixel(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
		settle();
		write_reg(REG_ROW_WIDTH, 16'd3);
		end_writes();
		push_pixel(OP_PIXEL, 8'd90, 8'd45, 8'd15);
		settle();

		// unit weights (left = red, right = blue, 255 exactly at the top),
		// stop mid-row, then shrink the width under the running row
		write_config(16'd7, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096);
		push_pixel(OP_PIXEL, 8'd255, 8'd9, 8'd0);
		push_pixel(OP_PIXEL, 8'd128, 8'd9, 8'd127);
		push_pixel(OP_PIXEL, 8'd1, 8'd9, 8'd254);
		push_pixel(OP_PIXEL, 8'd0, 8'd9, 8'd255);
		push_pixel(OP_PIXEL, 8'd77, 8'd9, 8'd66);
		settle();
		write_reg(REG_ROW_WIDTH, 16'd3);
		end_writes();
		push_pixel(OP_PIXEL, 8'd11, 8'd22, 8'd33);
		push_pixel(OP_PIXEL, 8'd44, 8'd55, 8'd66);
		push_pixel(OP_PIXEL, 8'd77, 8'd88, 8'd99);
		push_pixel(OP_DRAIN, 8'd0, 8'd0, 8'd0);

		// random phases: new settings each time, the source pauses until the
		// pipe is empty before every change
		rand_done = 0;
		while (rand_done < RANDOM_ITEMS) begin
			settle();
			write_config(rand_width(), rand_coef(), rand_coef(), rand_coef(),
				rand_coef(), rand_coef(), rand_coef());
			push_random($urandom_range(40, 160));
			rand_done += pixel_q.size();
			// now and then a whole drain row on narrow settings
			w_now = eff_width(width_reg);
			if (w_now <= 64 && $urandom_range(0, 4) == 0) begin
				for (int i = 0; i < w_now; i++)
					push_pixel(OP_DRAIN, rand_chan(), rand_chan(), rand_chan());
				rand_done += w_now;
			end
		end

		settle();
		if (due_pairs.size() != 0) begin
			errors++;
			$display("%0t: %0d byte pairs never arrived", $time, due_pairs.size());
		end
		if (errors == 0)
			$display("anaglyph_to_side_by_side_gray_tb: PASS");
		else
			$display("anaglyph_to_side_by_side_gray_tb: FAIL");
		$finish;
	end

endmodule
